// File: rtl/ped_pkg.sv
// Shared types and command codes for the prefix edit distance block.
`timescale 1ns / 1ps

package ped_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic [5:0] distance;
    logic       query_truncated;
  } rsp_t;

endpackage

// File: rtl/ped_cell.sv
// One row cell of the systolic edit distance column.
`timescale 1ns / 1ps

module ped_cell #(
  parameter int MAX_LEN = 32,
  parameter int INDEX   = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic                              wr_en,
  input  logic [7:0]                        wr_ch,
  input  logic                              in_valid,
  input  logic [7:0]                        in_ch,
  input  logic [$clog2(MAX_LEN + 2) - 1:0]  in_up,
  input  logic [$clog2(MAX_LEN + 2) - 1:0]  in_diag,
  output logic                              out_valid,
  output logic [7:0]                        out_ch,
  output logic [$clog2(MAX_LEN + 2) - 1:0]  out_up,
  output logic [$clog2(MAX_LEN + 2) - 1:0]  out_diag
);

  localparam int VW  = $clog2(MAX_LEN + 2);
  localparam int CAP = MAX_LEN + 1;

  logic [7:0]    qch;
  logic [VW-1:0] val;
  logic [VW-1:0] val_next;
  logic [VW:0]   from_left;
  logic [VW:0]   from_up;
  logic [VW:0]   from_diag;
  logic [VW:0]   best;

  always_comb begin
    from_left = {1'b0, val} + (VW + 1)'(1);
    from_up   = {1'b0, in_up} + (VW + 1)'(1);
    from_diag = {1'b0, in_diag} + (VW + 1)'(qch != in_ch);
    best = from_left;
    if (from_up < best) begin
      best = from_up;
    end
    if (from_diag < best) begin
      best = from_diag;
    end
    // saturate so the cell never outgrows its register
    if (best > (VW + 1)'(CAP)) begin
      val_next = VW'(CAP);
    end else begin
      val_next = best[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      qch <= wr_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      val <= VW'(INDEX);
    end else if (in_valid) begin
      val <= val_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_ch   <= in_ch;
      out_up   <= val_next;
      out_diag <= val;
    end
  end

endmodule

// File: rtl/prefix_edit_distance.sv
// Top level of the prefix edit distance block: request decode, cell chain, result register.
`timescale 1ns / 1ps

// Computes the smallest edit distance from a stored query (up to MAX_LEN characters) to any
// prefix of the streamed text. Text characters enter a chain of MAX_LEN row cells and are
// taken one per cycle, back to back; each moves down the chain one cell per cycle as a
// skewed wavefront. Clear, append and finish requests wait until the chain has drained,
// that is until the last text character has left the head register and every row cell; an idle
// chain does not stall them. A finish also waits while an earlier result is still held in the output
// register. Appends beyond MAX_LEN characters are dropped and reported as truncated.
module prefix_edit_distance #(
  parameter int MAX_LEN = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ped_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ped_pkg::rsp_t rsp
);

  localparam int VW  = $clog2(MAX_LEN + 2);
  localparam int QW  = $clog2(MAX_LEN + 1);
  localparam int CAP = MAX_LEN + 1;

  logic [MAX_LEN:0] link_valid;
  logic [7:0]       link_ch   [0:MAX_LEN];
  logic [VW-1:0]    link_up   [0:MAX_LEN];
  logic [VW-1:0]    link_diag [0:MAX_LEN];

  logic [QW-1:0] qlen;
  logic [VW-1:0] text_count;
  logic [VW-1:0] text_count_next;
  logic [VW-1:0] running_min;
  logic          truncated;

  logic chain_empty;
  logic accept;
  logic restart;
  logic append_acc;
  logic text_acc;
  logic finish_acc;
  logic qfull;
  logic take_min;

  assign chain_empty = ~|link_valid;
  assign qfull       = ({1'b0, qlen} == (QW + 1)'(MAX_LEN));

  // take the bottom cell of the query as its wavefront passes
  assign take_min    = link_valid[qlen] && link_up[qlen] < running_min;

  always_comb begin
    req_stall = 1'b0;
    if (req.cmd != ped_pkg::CMD_TEXT && !chain_empty) begin
      req_stall = 1'b1;
    end
    if (req.cmd == ped_pkg::CMD_FINISH && rsp_valid && rsp_stall) begin
      req_stall = 1'b1;
    end
  end

  assign accept     = req_valid && !req_stall;
  assign append_acc = accept && req.cmd == ped_pkg::CMD_APPEND;
  assign text_acc   = accept && req.cmd == ped_pkg::CMD_TEXT;
  assign finish_acc = accept && req.cmd == ped_pkg::CMD_FINISH;
  assign restart    = accept && (req.cmd == ped_pkg::CMD_CLEAR || req.cmd == ped_pkg::CMD_APPEND);

  assign text_count_next = (text_count == VW'(CAP)) ? text_count : text_count + VW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen        <= '0;
      text_count  <= '0;
      running_min <= '0;
      truncated   <= 1'b0;
    end else if (accept) begin
      case (req.cmd)
        ped_pkg::CMD_CLEAR: begin
          qlen        <= '0;
          text_count  <= '0;
          running_min <= '0;
          truncated   <= 1'b0;
        end
        ped_pkg::CMD_APPEND: begin
          text_count <= '0;
          if (qfull) begin
            truncated   <= 1'b1;
            running_min <= VW'(qlen);
          end else begin
            qlen        <= qlen + QW'(1);
            running_min <= VW'(qlen) + VW'(1);
          end
        end
        ped_pkg::CMD_TEXT: begin
          text_count <= text_count_next;
          if (take_min) begin
            running_min <= link_up[qlen];
          end
        end
        default: begin
        end
      endcase
    end else if (take_min) begin
      running_min <= link_up[qlen];
    end
  end

  // head of the chain: the top row holds the text count
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid[0] <= 1'b0;
    end else begin
      link_valid[0] <= text_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      link_ch[0]   <= req.ch;
      link_up[0]   <= text_count_next;
      link_diag[0] <= text_count;
    end
  end

  for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
    ped_cell #(
      .MAX_LEN (MAX_LEN),
      .INDEX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .restart   (restart),
      .wr_en     (append_acc && !qfull && qlen == QW'(i - 1)),
      .wr_ch     (req.ch),
      .in_valid  (link_valid[i-1]),
      .in_ch     (link_ch[i-1]),
      .in_up     (link_up[i-1]),
      .in_diag   (link_diag[i-1]),
      .out_valid (link_valid[i]),
      .out_ch    (link_ch[i]),
      .out_up    (link_up[i]),
      .out_diag  (link_diag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish_acc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_acc) begin
      rsp.distance        <= 6'(running_min);
      rsp.query_truncated <= truncated;
    end
  end

`ifndef SYNTH
  a_drained_before_control: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd != ped_pkg::CMD_TEXT) |-> chain_empty)
    else $error("control request taken while the chain still holds text");

  a_min_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, running_min} <= (VW + 1)'(qlen))
    else $error("running minimum above query length");

  a_truncated_full: assert property (@(posedge clk) disable iff (rst)
    truncated |-> qfull)
    else $error("truncation flagged with room left in the query");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    {1'b0, text_count} <= (VW + 1)'(CAP))
    else $error("text count past saturation");
`endif

endmodule
